FILE: design/hvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared widths, register indexes and bundle types of the vertex normal block.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MAX_WIDTH        = 256;
  localparam int MAX_HEIGHT       = 256;
  localparam int ADDR_W           = 8;
  localparam int DIM_W            = 9;
  localparam int HEIGHT_BITS      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int FACE_W           = HEIGHT_BITS + 1;
  localparam int SUM_W            = FACE_W + 2;
  localparam int SY_W             = 11;
  localparam int MAG_W            = SUM_W - 1;
  localparam int SQ_W             = 2 * MAG_W;
  localparam int LEN_W            = SQ_W + 2;
  localparam int QUO_W            = 2 * NORMAL_FRAC_BITS + 3;
  localparam int ROOT_W           = NORMAL_FRAC_BITS + 2;
  localparam int NX_W             = 16;
  localparam int NY_W             = 15;
  localparam int CIDX_W           = 1;

  localparam logic [SY_W-1:0] ONE_Y = SY_W'(1 << (HEIGHT_BITS / 2));

  localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [FACE_W-1:0] fx;
    logic signed [FACE_W-1:0] fz;
  } face_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sx;
    logic [SY_W-1:0]         sy;
    logic signed [SUM_W-1:0] sz;
  } norm_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [NX_W-1:0] nx;
    logic [NY_W-1:0]        ny;
    logic signed [NX_W-1:0] nz;
  } norm_rsp_t;

endpackage

FILE: design/heightmap_vertex_normals.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_vertex_normals
// Smooth per-vertex normals of a raster-ordered height grid, Q2.14 output.
// ----------------------------------------------------------------------------
// Sequence: an input transfer passes ST_RD1, ST_RD2 and ST_CALC, which starts
//   the normalizer; when it is done, ST_LOAD loads the result once the output
//   slot is free, and for a last-row vertex starts a second one as it loads.
// Flow: a new sample is taken only in ST_IDLE, after the results of the last
//   sample have loaded; a row-0 sample gives no result, a last-row sample two;
//   the divide and square-root loop and output stalls set the rate.
// Reset: synchronous, clears counters, faces, registers to 256x256; the line
//   buffers are not cleared, every entry is written before its value is used.
module heightmap_vertex_normals (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // [15:0] height_sample
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [63:0]                m_tdata,   // normal_x, normal_y, normal_z,
                                                // vertex_column, vertex_row, pad
  output logic                       m_tlast,   // last_of_run
  output logic                       m_tuser,   // end_of_grid
  input  logic                       cfg_we,
  input  logic [hvn_pkg::CIDX_W-1:0] cfg_index,
  input  logic [hvn_pkg::DIM_W-1:0]  cfg_data
);
  import hvn_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD1  = 3'd1;
  localparam logic [2:0] ST_RD2  = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_NORM = 3'd4;
  localparam logic [2:0] ST_LOAD = 3'd5;

  logic [2:0]                    state;
  logic [DIM_W-1:0]              grid_width;
  logic [DIM_W-1:0]              grid_height;
  logic [ADDR_W-1:0]             col_cnt;
  logic [ADDR_W-1:0]             row_cnt;
  face_t                         left_f;
  face_t                         diag_f;
  face_t                         face_q;
  logic signed [HEIGHT_BITS-1:0] h_in;
  logic signed [HEIGHT_BITS-1:0] up_h;
  logic [ADDR_W-1:0]             cur_c;
  logic [ADDR_W-1:0]             cur_r;
  logic                          lastrow_q;
  logic                          end_q;
  logic                          second_phase;
  logic signed [SUM_W-1:0]       sum2_x;
  logic [SY_W-1:0]               sum2_y;
  logic signed [SUM_W-1:0]       sum2_z;

  logic [HEIGHT_BITS-1:0]        hr_rdata;
  face_t                         fr_rdata;
  logic [ADDR_W-1:0]             hr_raddr;
  norm_req_t                     nreq;
  norm_rsp_t                     nrsp;

  logic [DIM_W-1:0]              w_eff;
  logic [DIM_W-1:0]              h_eff;
  logic                          cur_ok;
  logic                          left_ok;
  logic                          above;
  logic                          lastrow;
  logic                          col_wrap;
  face_t                         cf;
  logic signed [SUM_W-1:0]       s1x;
  logic signed [SUM_W-1:0]       s1z;
  logic [SY_W-1:0]               s1y;
  logic signed [SUM_W-1:0]       s2x;
  logic signed [SUM_W-1:0]       s2z;
  logic [SY_W-1:0]               s2y;
  logic                          slot_free;
  logic                          calc_emit;
  logic                          start_second;

  // clamp the grid registers into 2..MAX_WIDTH and 2..MAX_HEIGHT
  always_comb begin
    w_eff = (grid_width < DIM_W'(2)) ? DIM_W'(2) :
            (grid_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width;
    h_eff = (grid_height < DIM_W'(2)) ? DIM_W'(2) :
            (grid_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height;
  end

  // face of the quad to the right of the vertex above; zero past the last column
  always_comb begin
    cur_ok   = ({1'b0, col_cnt} + 1'b1) < w_eff;
    left_ok  = col_cnt != '0;
    above    = row_cnt >= ADDR_W'(2);
    lastrow  = ({1'b0, row_cnt} + 1'b1) == h_eff;
    col_wrap = !cur_ok;
    cf.fx    = cur_ok ? FACE_W'(up_h) - FACE_W'($signed(hr_rdata)) : '0;
    cf.fz    = cur_ok ? FACE_W'(up_h) - FACE_W'(h_in) : '0;

    s2x = '0;
    s2z = '0;
    s2y = '0;
    if (left_ok) begin
      s2x = s2x + SUM_W'(left_f.fx);
      s2z = s2z + SUM_W'(left_f.fz);
      s2y = s2y + ONE_Y;
    end
    if (cur_ok) begin
      s2x = s2x + SUM_W'(cf.fx);
      s2z = s2z + SUM_W'(cf.fz);
      s2y = s2y + ONE_Y;
    end
    s1x = s2x;
    s1z = s2z;
    s1y = s2y;
    if (above && left_ok) begin
      s1x = s1x + SUM_W'(diag_f.fx);
      s1z = s1z + SUM_W'(diag_f.fz);
      s1y = s1y + ONE_Y;
    end
    if (above && cur_ok) begin
      s1x = s1x + SUM_W'(face_q.fx);
      s1z = s1z + SUM_W'(face_q.fz);
      s1y = s1y + ONE_Y;
    end
  end

  assign slot_free    = !m_tvalid || m_tready;
  assign calc_emit    = (state == ST_CALC) && (row_cnt != '0);
  assign start_second = (state == ST_LOAD) && slot_free && lastrow_q && !second_phase;

  always_comb begin
    nreq.start = calc_emit || start_second;
    nreq.sx    = calc_emit ? s1x : sum2_x;
    nreq.sy    = calc_emit ? s1y : sum2_y;
    nreq.sz    = calc_emit ? s1z : sum2_z;
  end

  // read the sample above first, then the one above-right
  assign hr_raddr = (state == ST_RD2) ? col_cnt + 1'b1 : col_cnt;
  assign s_tready = (state == ST_IDLE);

  hvn_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_heights (
    .clk   (clk),
    .we    (state == ST_CALC),
    .waddr (col_cnt),
    .wdata (h_in),
    .raddr (hr_raddr),
    .rdata (hr_rdata)
  );

  hvn_ram #(.WIDTH($bits(face_t)), .DEPTH(MAX_WIDTH)) u_faces (
    .clk   (clk),
    .we    (calc_emit),
    .waddr (col_cnt),
    .wdata (cf),
    .raddr (col_cnt),
    .rdata (fr_rdata)
  );

  hvn_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .rsp (nrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      grid_width   <= DIM_W'(MAX_WIDTH);
      grid_height  <= DIM_W'(MAX_HEIGHT);
      col_cnt      <= '0;
      row_cnt      <= '0;
      left_f       <= '0;
      diag_f       <= '0;
      m_tvalid     <= 1'b0;
      second_phase <= 1'b0;
      lastrow_q    <= 1'b0;
    end else begin
      // drop valid after the transfer unless a new result loads in its place
      if (m_tready && (state != ST_LOAD)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        // any write outside ST_CALC restarts the grid
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
        col_cnt <= '0;
        row_cnt <= '0;
        left_f  <= '0;
        diag_f  <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            h_in  <= s_tdata;
            state <= ST_RD1;
          end
        end
        ST_RD1: state <= ST_RD2;
        ST_RD2: begin
          up_h   <= hr_rdata;
          face_q <= fr_rdata;
          state  <= ST_CALC;
        end
        ST_CALC: begin
          cur_c        <= col_cnt;
          cur_r        <= row_cnt - 1'b1;
          lastrow_q    <= lastrow;
          end_q        <= col_wrap;
          second_phase <= 1'b0;
          sum2_x       <= s2x;
          sum2_y       <= s2y;
          sum2_z       <= s2z;
          if (row_cnt != '0) begin
            diag_f <= face_q;
            left_f <= cf;
            state  <= ST_NORM;
          end else begin
            state <= ST_IDLE;
          end
          if (col_wrap) begin
            col_cnt <= '0;
            row_cnt <= lastrow ? '0 : row_cnt + 1'b1;
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
        end
        ST_NORM: begin
          if (nrsp.done) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, second_phase ? cur_r + 1'b1 : cur_r, cur_c,
                         nrsp.nz, nrsp.ny, nrsp.nx};
            m_tlast  <= second_phase || !lastrow_q;
            m_tuser  <= second_phase && end_q;
            if (start_second) begin
              second_phase <= 1'b1;
              state        <= ST_NORM;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/hvn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/hvn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_norm
// Serial normalizer: length squared, then per component a restoring divide
// and a digit-by-digit square root give the rounded unit component.
// ----------------------------------------------------------------------------
module hvn_norm (
  input  logic                clk,
  input  logic                rst,
  input  hvn_pkg::norm_req_t  req,
  output hvn_pkg::norm_rsp_t  rsp
);
  import hvn_pkg::*;

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_ACC  = 3'd2;
  localparam logic [2:0] N_CSQ  = 3'd3;
  localparam logic [2:0] N_DIVI = 3'd4;
  localparam logic [2:0] N_DIV  = 3'd5;
  localparam logic [2:0] N_SQRT = 3'd6;

  logic [2:0]              state;
  logic [1:0]              k;
  logic [MAG_W-1:0]        mag [3];
  logic [2:0]              neg;
  logic [SQ_W-1:0]         prod;
  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        rem;
  logic                    b0;
  logic [QUO_W-1:0]        quo;
  logic [4:0]              cnt;
  logic [QUO_W:0]          qsh;
  logic [ROOT_W+2:0]       sq_rem;
  logic [ROOT_W-1:0]       root;
  logic signed [NX_W-1:0]  res [3];
  logic                    done;

  logic [LEN_W:0]          dtry;
  logic                    dge;
  logic [QUO_W-1:0]        quo_next;
  logic [ROOT_W+2:0]       r2;
  logic [ROOT_W+2:0]       trial;
  logic                    sge;
  logic [ROOT_W-1:0]       root_next;
  logic [ROOT_W-1:0]       lo;
  logic signed [SUM_W-1:0] sx_abs;
  logic signed [SUM_W-1:0] sz_abs;

  always_comb begin
    sx_abs    = req.sx[SUM_W-1] ? -req.sx : req.sx;
    sz_abs    = req.sz[SUM_W-1] ? -req.sz : req.sz;
    dtry      = {rem, (cnt == 5'd0) ? b0 : 1'b0};
    dge       = dtry >= {1'b0, len};
    quo_next  = {quo[QUO_W-2:0], dge};
    r2        = {sq_rem[ROOT_W:0], qsh[QUO_W:QUO_W-1]};
    trial     = {1'b0, root, 2'b01};
    sge       = r2 >= trial;
    root_next = {root[ROOT_W-2:0], sge};
    lo        = ROOT_W'(({1'b0, root_next} + 1'b1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      k     <= 2'd0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (req.start) begin
            mag[0] <= sx_abs[MAG_W-1:0];
            mag[1] <= MAG_W'(req.sy);
            mag[2] <= sz_abs[MAG_W-1:0];
            neg    <= {req.sz[SUM_W-1], 1'b0, req.sx[SUM_W-1]};
            len    <= '0;
            k      <= 2'd0;
            state  <= N_SQ;
          end
        end
        N_SQ: begin
          prod  <= mag[k] * mag[k];
          state <= N_ACC;
        end
        N_ACC: begin
          len <= len + LEN_W'(prod);
          if (k == 2'd2) begin
            k     <= 2'd0;
            state <= N_CSQ;
          end else begin
            k     <= k + 2'd1;
            state <= N_SQ;
          end
        end
        N_CSQ: begin
          prod  <= mag[k] * mag[k];
          state <= N_DIVI;
        end
        N_DIVI: begin
          // the quotient has at most QUO_W bits, so start with the top of the dividend
          rem   <= LEN_W'(prod[SQ_W-1:1]);
          b0    <= prod[0];
          quo   <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          rem <= dge ? LEN_W'(dtry - {1'b0, len}) : dtry[LEN_W-1:0];
          quo <= quo_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QUO_W - 1)) begin
            qsh    <= {1'b0, quo_next};
            sq_rem <= '0;
            root   <= '0;
            cnt    <= '0;
            state  <= N_SQRT;
          end
        end
        N_SQRT: begin
          sq_rem <= sge ? r2 - trial : r2;
          root   <= root_next;
          qsh    <= {qsh[QUO_W-2:0], 2'b00};
          cnt    <= cnt + 5'd1;
          if (cnt == 5'(ROOT_W - 1)) begin
            res[k] <= neg[k] ? -$signed(lo) : $signed(lo);
            if (k == 2'd2) begin
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              k     <= k + 2'd1;
              state <= N_CSQ;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.nx   = res[0];
  assign rsp.ny   = res[1][NY_W-1:0];
  assign rsp.nz   = res[2];

endmodule

FILE: design/hvn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_checker
// Port-level assertions for the vertex normal block, bound to the top level.
// ----------------------------------------------------------------------------
module hvn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("end of grid not on last result of a run");

  a_ny_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[30:16] != 15'd0 && m_tdata[30:16] <= 15'd16384)
    else $error("normal y out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sample accepted back to back");

endmodule

bind heightmap_vertex_normals hvn_checker u_hvn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
